@@ sv/armed_motion_alarm_detector_defines.svh @@
// assertion macros for the armed motion alarm detector checker
// no dependencies; clock and reset names come from the including module
`ifndef ARMED_MOTION_ALARM_DETECTOR_DEFINES_SVH
`define ARMED_MOTION_ALARM_DETECTOR_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define AMAD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication with the consequent checked in the cycle after the trigger
`define AMAD_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/amad_pkg.sv @@
// shared types and constants for the armed motion alarm detector
// no dependencies
package amad_pkg;

   localparam int ACCEL_W = 16;
   localparam int DEV_W = 18;
   localparam int MUTE_MIN_W = 16;
   localparam int MUTE_W = 22;
   localparam int RUN_W = 8;
   localparam int COOL_W = 8;
   localparam int GRACE_W = 16;
   localparam int CSR_W = 18;
   localparam int CSR_IDX_W = 2;
   localparam int ACTION_W = 2;
   localparam int NUM_LANES = 3;
   localparam int BASELINE_COUNT_DEF = 3;

   localparam logic [DEV_W-1:0] DELTA_THRESHOLD_RST = DEV_W'(1500);
   localparam logic [RUN_W-1:0] CONSECUTIVE_NEEDED_RST = RUN_W'(2);
   localparam logic [COOL_W-1:0] COOLDOWN_TICKS_RST = COOL_W'(15);
   localparam logic [GRACE_W-1:0] GRACE_TICKS_RST = GRACE_W'(20);

   typedef enum logic [ACTION_W-1:0] {
      ACT_SAMPLE = 2'd0,
      ACT_FAIL = 2'd1,
      ACT_MUTE = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELTA_THRESHOLD = 2'd0,
      CSR_CONSECUTIVE_NEEDED = 2'd1,
      CSR_COOLDOWN_TICKS = 2'd2,
      CSR_GRACE_TICKS = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DEV_W-1:0] delta_threshold;
      logic [RUN_W-1:0] consecutive_needed;
      logic [COOL_W-1:0] cooldown_ticks;
      logic [GRACE_W-1:0] grace_ticks;
   } cfg_type;

   typedef struct packed {
      logic accumulate;
      logic finish;
      logic track;
   } lane_ctrl_type;

   typedef struct packed {
      logic alert;
      logic motion_detected;
      logic guard_armed;
      logic baseline_valid;
      logic [DEV_W-1:0] deviation;
   } result_type;

endpackage

@@ sv/amad_lane.sv @@
// one axis lane: baseline accumulation, average, tracking filter and absolute deviation
// depends on amad_pkg
module amad_lane #(
   parameter int BASELINE_COUNT = amad_pkg::BASELINE_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [amad_pkg::ACCEL_W-1:0] sample,
   input  amad_pkg::lane_ctrl_type             ctrl,
   output logic        [amad_pkg::ACCEL_W-1:0] absdiff
);
   import amad_pkg::*;

   localparam int SUM_W = ACCEL_W + $clog2(BASELINE_COUNT + 1);
   localparam int DIV_SHIFT = SUM_W + 2;
   localparam int RECIP_W = DIV_SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << DIV_SHIFT) + BASELINE_COUNT - 1) / BASELINE_COUNT);
   localparam int PROD_W = SUM_W + RECIP_W;
   localparam int TRK_W = ACCEL_W + 4;
   localparam logic signed [TRK_W-1:0] TRK_ROUND = TRK_W'(7);

   logic signed [ACCEL_W-1:0] base_ff, base_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [ACCEL_W:0]   diff;
   logic signed [TRK_W-1:0]   trk_sum, trk_q;
   logic                      sum_neg;
   logic [SUM_W-1:0]          sum_mag;
   logic [PROD_W-1:0]         prod;
   logic [ACCEL_W-1:0]        quot;
   logic signed [ACCEL_W-1:0] base_div;

   always_comb begin
      diff = (ACCEL_W+1)'(sample) - (ACCEL_W+1)'(base_ff);
      absdiff = diff[ACCEL_W] ? ACCEL_W'(-diff) : ACCEL_W'(diff);

      // (7*base + sample)/8, toward zero
      trk_sum = (TRK_W'(base_ff) <<< 3) - TRK_W'(base_ff) + TRK_W'(sample);
      trk_q = trk_sum[TRK_W-1] ? ((trk_sum + TRK_ROUND) >>> 3) : (trk_sum >>> 3);

      // sum / BASELINE_COUNT by reciprocal on the magnitude
      sum_in = sum_ff + SUM_W'(sample);
      sum_neg = sum_in[SUM_W-1];
      sum_mag = sum_neg ? SUM_W'(-sum_in) : SUM_W'(sum_in);
      prod = PROD_W'(sum_mag) * PROD_W'(RECIP);
      quot = prod[DIV_SHIFT +: ACCEL_W];
      base_div = sum_neg ? ACCEL_W'(-quot) : quot;

      if (ctrl.finish) begin
         base_in = base_div;
      end else if (ctrl.track) begin
         base_in = ACCEL_W'(trk_q);
      end else begin
         base_in = base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         sum_ff <= '0;
      end else begin
         base_ff <= base_in;
         if (ctrl.accumulate) begin
            sum_ff <= sum_in;
         end
      end
   end

endmodule

@@ sv/amad_merge.sv @@
// merging stage: deviation sum, baseline count, arming, mute, candidate run and cooldown control
// depends on amad_pkg; drives the lane controls
module amad_merge #(
   parameter int BASELINE_COUNT = amad_pkg::BASELINE_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [amad_pkg::ACTION_W-1:0]        action,
   input  logic                                 ignition_on,
   input  logic                                 alert_ready,
   input  logic [amad_pkg::MUTE_MIN_W-1:0]      mute_minutes,
   input  logic [amad_pkg::ACCEL_W-1:0]         lane_absdiff [amad_pkg::NUM_LANES],
   input  amad_pkg::cfg_type                    cfg,
   output amad_pkg::lane_ctrl_type              lane_ctrl,
   output amad_pkg::result_type                 result
);
   import amad_pkg::*;

   localparam int CNT_W = $clog2(BASELINE_COUNT + 1);

   logic [CNT_W-1:0]   bl_count_ff, bl_count_in;
   logic               bl_done_ff, bl_done_in;
   logic               armed_ff, armed_in;
   logic [GRACE_W-1:0] grace_ff, grace_in;
   logic [MUTE_W-1:0]  mute_ff, mute_in;
   logic [RUN_W-1:0]   cand_ff, cand_in;
   logic [COOL_W-1:0]  cool_ff, cool_in;
   logic [DEV_W-1:0]   dev_sum;
   logic [MUTE_W-1:0]  mute_load;
   lane_ctrl_type      ctrl;

   always_comb begin
      dev_sum = DEV_W'(lane_absdiff[0]) + DEV_W'(lane_absdiff[1]) + DEV_W'(lane_absdiff[2]);
      // minutes to seconds: 64m - 4m
      mute_load = (MUTE_W'(mute_minutes) << 6) - (MUTE_W'(mute_minutes) << 2);

      bl_count_in = bl_count_ff;
      bl_done_in = bl_done_ff;
      armed_in = armed_ff;
      grace_in = grace_ff;
      mute_in = mute_ff;
      cand_in = cand_ff;
      cool_in = cool_ff;
      ctrl = '0;
      result.alert = 1'b0;
      result.motion_detected = 1'b0;
      result.deviation = '0;

      unique case (action_type'(action))
         ACT_MUTE: begin
            mute_in = mute_load;
         end
         ACT_FAIL: begin
            if (cool_ff != '0) begin
               cool_in = cool_ff - 1'b1;
            end
         end
         ACT_SAMPLE: begin
            if (ignition_on && armed_ff) begin
               armed_in = 1'b0;
               cand_in = '0;
               grace_in = '0;
            end else if (!ignition_on && !armed_ff && grace_ff == '0) begin
               grace_in = cfg.grace_ticks;
               cand_in = '0;
            end
            if (grace_in != '0) begin
               grace_in = grace_in - 1'b1;
               if (grace_in == '0 && !ignition_on) begin
                  armed_in = 1'b1;
               end
            end
            if (mute_ff != '0) begin
               mute_in = mute_ff - 1'b1;
            end

            if (!bl_done_ff) begin
               ctrl.accumulate = 1'b1;
               bl_count_in = bl_count_ff + 1'b1;
               if (bl_count_in >= CNT_W'(BASELINE_COUNT)) begin
                  ctrl.finish = 1'b1;
                  bl_done_in = 1'b1;
               end
            end else begin
               ctrl.track = 1'b1;
               result.deviation = dev_sum;
               if (armed_in && mute_in == '0 && dev_sum >= cfg.delta_threshold) begin
                  cand_in = cand_in + 1'b1;
               end else begin
                  cand_in = '0;
               end
               if (cand_in >= cfg.consecutive_needed) begin
                  result.motion_detected = 1'b1;
                  if (cool_ff == '0) begin
                     result.alert = 1'b1;
                     if (alert_ready) begin
                        cool_in = cfg.cooldown_ticks;
                     end
                  end
                  cand_in = '0;
               end
            end

            if (cool_in != '0) begin
               cool_in = cool_in - 1'b1;
            end
         end
         default: begin
         end
      endcase

      result.guard_armed = armed_in;
      result.baseline_valid = bl_done_in;
      lane_ctrl = accept ? ctrl : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bl_count_ff <= '0;
         bl_done_ff <= 1'b0;
         armed_ff <= 1'b0;
         grace_ff <= '0;
         mute_ff <= '0;
         cand_ff <= '0;
         cool_ff <= '0;
      end else if (accept) begin
         bl_count_ff <= bl_count_in;
         bl_done_ff <= bl_done_in;
         armed_ff <= armed_in;
         grace_ff <= grace_in;
         mute_ff <= mute_in;
         cand_ff <= cand_in;
         cool_ff <= cool_in;
      end
   end

endmodule

@@ sv/armed_motion_alarm_detector.sv @@
// armed motion alarm detector: an accepted result is registered into the output register,
// or into the skid entry while the output is stalled; throughput one transaction per cycle
// while req_stall is low; the three axis lanes and the merging stage update all state in the
// accepting cycle, and a two-entry output buffer keeps accepting while one result is stalled
// synchronous reset clears all state but the output data registers and loads the register defaults
// depends on amad_pkg, amad_lane, amad_merge
module armed_motion_alarm_detector #(
   parameter int BASELINE_COUNT = amad_pkg::BASELINE_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic        [amad_pkg::ACTION_W-1:0]   req_action,
   input  logic signed [amad_pkg::ACCEL_W-1:0]    req_accel_x,
   input  logic signed [amad_pkg::ACCEL_W-1:0]    req_accel_y,
   input  logic signed [amad_pkg::ACCEL_W-1:0]    req_accel_z,
   input  logic                                req_ignition_on,
   input  logic                                req_alert_ready,
   input  logic        [amad_pkg::MUTE_MIN_W-1:0] req_mute_minutes,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_alert,
   output logic                                rsp_motion_detected,
   output logic                                rsp_guard_armed,
   output logic                                rsp_baseline_valid,
   output logic        [amad_pkg::DEV_W-1:0]      rsp_deviation,
   input  logic                                csr_write,
   input  logic        [amad_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [amad_pkg::CSR_W-1:0]      csr_data
);
   import amad_pkg::*;

   cfg_type                   cfg_ff, cfg_in;
   logic                      accept;
   logic                      take;
   logic signed [ACCEL_W-1:0] samples [NUM_LANES];
   logic [ACCEL_W-1:0]        lane_absdiff [NUM_LANES];
   lane_ctrl_type             lane_ctrl;
   result_type                result;
   logic                      out_valid_ff, out_valid_in;
   result_type                out_data_ff, out_data_in;
   logic                      skid_valid_ff, skid_valid_in;
   result_type                skid_data_ff, skid_data_in;

   assign samples[0] = req_accel_x;
   assign samples[1] = req_accel_y;
   assign samples[2] = req_accel_z;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_DELTA_THRESHOLD:    cfg_in.delta_threshold = DEV_W'(csr_data);
            CSR_CONSECUTIVE_NEEDED: cfg_in.consecutive_needed = RUN_W'(csr_data);
            CSR_COOLDOWN_TICKS:     cfg_in.cooldown_ticks = COOL_W'(csr_data);
            CSR_GRACE_TICKS:        cfg_in.grace_ticks = GRACE_W'(csr_data);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delta_threshold <= DELTA_THRESHOLD_RST;
         cfg_ff.consecutive_needed <= CONSECUTIVE_NEEDED_RST;
         cfg_ff.cooldown_ticks <= COOLDOWN_TICKS_RST;
         cfg_ff.grace_ticks <= GRACE_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      amad_lane #(
         .BASELINE_COUNT(BASELINE_COUNT)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .sample (samples[i]),
         .ctrl   (lane_ctrl),
         .absdiff(lane_absdiff[i])
      );
   end

   amad_merge #(
      .BASELINE_COUNT(BASELINE_COUNT)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (req_action),
      .ignition_on (req_ignition_on),
      .alert_ready (req_alert_ready),
      .mute_minutes(req_mute_minutes),
      .lane_absdiff(lane_absdiff),
      .cfg         (cfg_ff),
      .lane_ctrl   (lane_ctrl),
      .result      (result)
   );

   // output register plus skid entry
   assign req_stall = skid_valid_ff;
   assign accept = req_valid && !skid_valid_ff;
   assign take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in = result;
         end
      end else if (!out_valid_ff) begin
         out_valid_in = accept;
         out_data_in = result;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_alert = out_data_ff.alert;
   assign rsp_motion_detected = out_data_ff.motion_detected;
   assign rsp_guard_armed = out_data_ff.guard_armed;
   assign rsp_baseline_valid = out_data_ff.baseline_valid;
   assign rsp_deviation = out_data_ff.deviation;

endmodule

@@ sv/amad_checker.sv @@
// port-level checker for the armed motion alarm detector, bound to the top level
// depends on amad_pkg and armed_motion_alarm_detector_defines.svh
`include "armed_motion_alarm_detector_defines.svh"

module amad_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic                       rsp_alert,
   input logic                       rsp_motion_detected,
   input logic                       rsp_guard_armed,
   input logic                       rsp_baseline_valid,
   input logic [amad_pkg::DEV_W-1:0] rsp_deviation
);
   import amad_pkg::*;

   `AMAD_ASSERT(a_alert_has_motion, !rsp_valid || !rsp_alert || rsp_motion_detected, "alert without motion")
   `AMAD_ASSERT(a_motion_has_baseline, !rsp_valid || !rsp_motion_detected || rsp_baseline_valid, "motion before baseline")
   `AMAD_ASSERT(a_dev_has_baseline, !rsp_valid || rsp_deviation == '0 || rsp_baseline_valid, "deviation before baseline")
   `AMAD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_alert) && $stable(rsp_motion_detected) && $stable(rsp_guard_armed) && $stable(rsp_baseline_valid) && $stable(rsp_deviation), "stalled transaction changed")

endmodule

bind armed_motion_alarm_detector amad_checker u_amad_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_alert          (rsp_alert),
   .rsp_motion_detected(rsp_motion_detected),
   .rsp_guard_armed    (rsp_guard_armed),
   .rsp_baseline_valid (rsp_baseline_valid),
   .rsp_deviation      (rsp_deviation)
);

@@ dv/tb.sv @@
// self-checking testbench for armed_motion_alarm_detector: directed and random ticks,
// a transaction-level predictor of arming, baseline, candidate run, mute and cooldown
// depends on amad_pkg and the armed_motion_alarm_detector RTL
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import amad_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SAMPLES_PER_BASELINE = BASELINE_COUNT_DEF;

   typedef struct {
      logic [ACTION_W-1:0]          action;
      logic signed [ACCEL_W-1:0]    accel_x;
      logic signed [ACCEL_W-1:0]    accel_y;
      logic signed [ACCEL_W-1:0]    accel_z;
      logic                         ignition_on;
      logic                         alert_ready;
      logic [MUTE_MIN_W-1:0]        mute_minutes;
   } tick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ACTION_W-1:0] req_action = '0;
   logic signed [ACCEL_W-1:0] req_accel_x = '0;
   logic signed [ACCEL_W-1:0] req_accel_y = '0;
   logic signed [ACCEL_W-1:0] req_accel_z = '0;
   logic req_ignition_on = 1'b0;
   logic req_alert_ready = 1'b0;
   logic [MUTE_MIN_W-1:0] req_mute_minutes = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_alert;
   logic rsp_motion_detected;
   logic rsp_guard_armed;
   logic rsp_baseline_valid;
   logic [DEV_W-1:0] rsp_deviation;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_data = '0;

   armed_motion_alarm_detector u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_accel_x         (req_accel_x),
      .req_accel_y         (req_accel_y),
      .req_accel_z         (req_accel_z),
      .req_ignition_on     (req_ignition_on),
      .req_alert_ready     (req_alert_ready),
      .req_mute_minutes    (req_mute_minutes),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_alert           (rsp_alert),
      .rsp_motion_detected (rsp_motion_detected),
      .rsp_guard_armed     (rsp_guard_armed),
      .rsp_baseline_valid  (rsp_baseline_valid),
      .rsp_deviation       (rsp_deviation),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow configuration and detector state
   logic [DEV_W-1:0]   cfg_threshold = DELTA_THRESHOLD_RST;
   logic [RUN_W-1:0]   cfg_needed = CONSECUTIVE_NEEDED_RST;
   logic [COOL_W-1:0]  cfg_cooldown = COOLDOWN_TICKS_RST;
   logic [GRACE_W-1:0] cfg_grace = GRACE_TICKS_RST;

   int base_x = 0, base_y = 0, base_z = 0;
   int sum_x = 0, sum_y = 0, sum_z = 0;
   int bl_sample_count = 0;
   bit baseline_done = 1'b0;
   bit armed = 1'b0;
   int grace_left = 0;
   int mute_left = 0;
   logic [RUN_W-1:0] run_len = '0;
   int cooldown_left = 0;

   result_type pending_alarm_results[$];
   int error_count = 0;
   int result_index = 0;
   int idle_cycles = 0;
   bit gaps_on = 1'b1;
   int hold_cycles = 0;
   int center_x = 0, center_y = 0, center_z = 0;

   function automatic result_type predict_alarm_result(tick_type t);
      result_type r;
      int sx, sy, sz, dev;
      r = '0;
      dev = 0;
      if (t.action == ACT_MUTE) begin
         mute_left = int'(t.mute_minutes) * 60;
      end else if (t.action == ACT_SAMPLE) begin
         sx = int'(t.accel_x);
         sy = int'(t.accel_y);
         sz = int'(t.accel_z);
         if (t.ignition_on && armed) begin
            armed = 1'b0;
            run_len = '0;
            grace_left = 0;
         end else if (!t.ignition_on && !armed && grace_left == 0) begin
            grace_left = int'(cfg_grace);
            run_len = '0;
         end
         if (grace_left > 0) begin
            grace_left--;
            if (grace_left == 0 && !t.ignition_on) armed = 1'b1;
         end
         if (mute_left > 0) mute_left--;
         if (!baseline_done) begin
            sum_x += sx;
            sum_y += sy;
            sum_z += sz;
            bl_sample_count++;
            if (bl_sample_count >= SAMPLES_PER_BASELINE) begin
               base_x = sum_x / SAMPLES_PER_BASELINE;
               base_y = sum_y / SAMPLES_PER_BASELINE;
               base_z = sum_z / SAMPLES_PER_BASELINE;
               baseline_done = 1'b1;
            end
         end else begin
            dev = (sx > base_x ? sx - base_x : base_x - sx)
                + (sy > base_y ? sy - base_y : base_y - sy)
                + (sz > base_z ? sz - base_z : base_z - sz);
            if (armed && mute_left == 0 && dev >= int'(cfg_threshold)) run_len = run_len + 1'b1;
            else run_len = '0;
            if (run_len >= cfg_needed) begin
               r.motion_detected = 1'b1;
               if (cooldown_left == 0) begin
                  r.alert = 1'b1;
                  if (t.alert_ready) cooldown_left = int'(cfg_cooldown);
               end
               run_len = '0;
            end
            base_x = (base_x * 7 + sx) / 8;
            base_y = (base_y * 7 + sy) / 8;
            base_z = (base_z * 7 + sz) / 8;
         end
      end
      if ((t.action == ACT_SAMPLE || t.action == ACT_FAIL) && cooldown_left > 0) cooldown_left--;
      r.guard_armed = armed;
      r.baseline_valid = baseline_done;
      r.deviation = DEV_W'(dev);
      return r;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (!gaps_on || p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic tick_type command_tick(logic [ACTION_W-1:0] act, int unsigned minutes);
      tick_type t;
      t.action = act;
      t.accel_x = ACCEL_W'($urandom);
      t.accel_y = ACCEL_W'($urandom);
      t.accel_z = ACCEL_W'($urandom);
      t.ignition_on = 1'($urandom_range(0, 1));
      t.alert_ready = 1'($urandom_range(0, 1));
      t.mute_minutes = MUTE_MIN_W'(minutes);
      return t;
   endfunction

   function automatic tick_type sample_tick(int x, int y, int z, bit ign, bit ready);
      tick_type t;
      t = command_tick(ACT_SAMPLE, $urandom_range(0, 65535));
      t.accel_x = ACCEL_W'(x);
      t.accel_y = ACCEL_W'(y);
      t.accel_z = ACCEL_W'(z);
      t.ignition_on = ign;
      t.alert_ready = ready;
      return t;
   endfunction

   function automatic int jitter(int c);
      int p, v;
      p = $urandom_range(0, 99);
      if (p < 70) v = c + int'($urandom_range(0, 600)) - 300;
      else if (p < 90) v = c + int'($urandom_range(0, 16000)) - 8000;
      else v = int'($urandom_range(0, 65535)) - 32768;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   function automatic tick_type random_tick();
      int p;
      int unsigned minutes;
      p = $urandom_range(0, 99);
      if (p < 6) return command_tick(ACT_FAIL, $urandom_range(0, 65535));
      if (p < 9) begin
         p = $urandom_range(0, 9);
         minutes = p < 5 ? 0 : (p < 8 ? 1 : $urandom_range(0, 65535));
         return command_tick(ACT_MUTE, minutes);
      end
      if (p < 10) return command_tick(ACT_RESERVED, $urandom_range(0, 65535));
      return sample_tick(jitter(center_x), jitter(center_y), jitter(center_z),
                         $urandom_range(0, 99) < 8, $urandom_range(0, 3) != 0);
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR result %0d: %s", result_index, msg);
      error_count++;
   endtask

   task automatic send_tick(tick_type t);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_action <= t.action;
      req_accel_x <= t.accel_x;
      req_accel_y <= t.accel_y;
      req_accel_z <= t.accel_z;
      req_ignition_on <= t.ignition_on;
      req_alert_ready <= t.alert_ready;
      req_mute_minutes <= t.mute_minutes;
      do @(posedge clock); while (req_stall);
      pending_alarm_results.push_back(predict_alarm_result(t));
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_alarm_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, int unsigned value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_W'(value);
      case (idx)
         CSR_DELTA_THRESHOLD:    cfg_threshold = DEV_W'(value);
         CSR_CONSECUTIVE_NEEDED: cfg_needed = RUN_W'(value);
         CSR_COOLDOWN_TICKS:     cfg_cooldown = COOL_W'(value);
         CSR_GRACE_TICKS:        cfg_grace = GRACE_W'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure(int unsigned th, int unsigned need, int unsigned cool,
                            int unsigned grace);
      settle();
      write_register(CSR_DELTA_THRESHOLD, th);
      write_register(CSR_CONSECUTIVE_NEEDED, need);
      write_register(CSR_COOLDOWN_TICKS, cool);
      write_register(CSR_GRACE_TICKS, grace);
   endtask

   task automatic test_directed();
      configure(1500, 2, 3, 2);
      send_tick(sample_tick(32767, -32768, 0, 1'b0, 1'b1));
      send_tick(command_tick(ACT_FAIL, 0));
      send_tick(sample_tick(-32768, 32767, -32768, 1'b0, 1'b1));
      send_tick(sample_tick(0, 0, 32767, 1'b0, 1'b1));
      send_tick(sample_tick(0, 0, 0, 1'b0, 1'b1));
      send_tick(sample_tick(32767, 32767, 32767, 1'b0, 1'b1));
      send_tick(sample_tick(-32768, -32768, -32768, 1'b0, 1'b1));
      send_tick(sample_tick(32767, 32767, 32767, 1'b0, 1'b1));
      send_tick(sample_tick(-32768, -32768, -32768, 1'b0, 1'b1));
      send_tick(command_tick(ACT_FAIL, 65535));
      send_tick(command_tick(ACT_MUTE, 1));
      send_tick(sample_tick(32767, 32767, 32767, 1'b0, 1'b1));
      send_tick(command_tick(ACT_MUTE, 0));
      send_tick(command_tick(ACT_RESERVED, 65535));
      send_tick(sample_tick(-32768, -32768, -32768, 1'b0, 1'b0));
      send_tick(sample_tick(32767, 32767, 32767, 1'b0, 1'b0));
      // ignition disarms, then ignition returns while grace runs
      send_tick(sample_tick(-32768, -32768, -32768, 1'b1, 1'b1));
      send_tick(sample_tick(0, 0, 0, 1'b0, 1'b1));
      send_tick(sample_tick(0, 0, 0, 1'b1, 1'b1));
      send_tick(sample_tick(-1, -1, -1, 1'b0, 1'b1));
      send_tick(sample_tick(1, 1, 1, 1'b0, 1'b1));
      send_tick(command_tick(ACT_MUTE, 65535));
      send_tick(sample_tick(-1, 32767, -32768, 1'b0, 1'b1));
      send_tick(command_tick(ACT_MUTE, 0));
   endtask

   task automatic test_zero_grace_and_count();
      configure(1500, 0, 2, 0);
      send_tick(sample_tick(100, -100, 50, 1'b1, 1'b1));
      repeat (6) send_tick(sample_tick(jitter(0), jitter(0), jitter(0), 1'b0, 1'b1));
      send_tick(command_tick(ACT_FAIL, 0));
      send_tick(sample_tick(0, 0, 0, 1'b0, 1'b0));
   endtask

   task automatic test_run_wrap();
      configure(0, 255, 0, 1);
      repeat (270) begin
         send_tick(sample_tick(int'($urandom_range(0, 65535)) - 32768,
                               int'($urandom_range(0, 65535)) - 32768,
                               int'($urandom_range(0, 65535)) - 32768, 1'b0, 1'b1));
      end
   endtask

   task automatic run_phase(int unsigned th, int unsigned need, int unsigned cool,
                            int unsigned grace, int n, bit gaps);
      configure(th, need, cool, grace);
      gaps_on = gaps;
      center_x = int'($urandom_range(0, 40000)) - 20000;
      center_y = int'($urandom_range(0, 40000)) - 20000;
      center_z = int'($urandom_range(0, 40000)) - 20000;
      repeat (n) send_tick(random_tick());
      gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      run_phase(int'(DELTA_THRESHOLD_RST), int'(CONSECUTIVE_NEEDED_RST),
                int'(COOLDOWN_TICKS_RST), int'(GRACE_TICKS_RST), 110, 1'b1);
      run_phase(196605, 255, 255, 65535, 60, 1'b1);
      run_phase(0, 1, 0, 1, 110, 1'b0);
      repeat (3) begin
         run_phase($urandom_range(300, 6000), $urandom_range(1, 4), $urandom_range(0, 20),
                   $urandom_range(1, 8), 110, 1'b1);
      end
   endtask

   always @(negedge clock) begin
      if (hold_cycles == 0) begin
         rsp_stall <= gaps_on && $urandom_range(0, 2) == 0;
         hold_cycles = $urandom_range(0, 19) == 0 ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 3);
      end else begin
         hold_cycles--;
      end
   end

   always @(posedge clock) begin
      result_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_alarm_results.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
         end else begin
            exp = pending_alarm_results.pop_front();
            if (rsp_alert !== exp.alert)
               report_mismatch($sformatf("alert %b, expected %b", rsp_alert, exp.alert));
            if (rsp_motion_detected !== exp.motion_detected)
               report_mismatch($sformatf("motion_detected %b, expected %b",
                                         rsp_motion_detected, exp.motion_detected));
            if (rsp_guard_armed !== exp.guard_armed)
               report_mismatch($sformatf("guard_armed %b, expected %b",
                                         rsp_guard_armed, exp.guard_armed));
            if (rsp_baseline_valid !== exp.baseline_valid)
               report_mismatch($sformatf("baseline_valid %b, expected %b",
                                         rsp_baseline_valid, exp.baseline_valid));
            if (rsp_deviation !== exp.deviation)
               report_mismatch($sformatf("deviation %0d, expected %0d",
                                         rsp_deviation, exp.deviation));
         end
         result_index++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("armed_motion_alarm_detector: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_zero_grace_and_count();
      test_run_wrap();
      test_random_traffic();
      settle();
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_alarm_results.size() == 0) begin
         $display("armed_motion_alarm_detector: match");
      end else begin
         $display("armed_motion_alarm_detector: mismatch");
      end
      $finish;
   end

endmodule

@@ armed_motion_alarm_detector.f @@
+incdir+sv
sv/amad_pkg.sv
sv/amad_lane.sv
sv/amad_merge.sv
sv/armed_motion_alarm_detector.sv
sv/amad_checker.sv
dv/tb.sv
